// File: rtl/core/rgb_window_median_filter_assert.svh
// assertion macros for the rgb window median filter
// used at the end of the top level, expects clk and arst_n in scope
`ifndef RGB_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define RGB_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RWMF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define RWMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/rwmf_pkg.sv
// shared types and constants of the rgb window median filter
// no dependencies
package rwmf_pkg;

	localparam int MAX_WINDOW = 15;
	localparam int MAX_WIDTH  = 2048;
	localparam int BINS       = 256;

	localparam int NCH      = 3;
	localparam int BIN_W    = 8;
	localparam int PIX_W    = NCH * BIN_W;
	localparam int WIN_W    = 4;
	localparam int CFG_W    = 12;
	localparam int IDX_W    = 2;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int ROW_W    = CFG_W;
	localparam int SLOT_W   = $clog2(MAX_WINDOW);
	localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
	localparam int LS_AW    = SLOT_W + COL_W;
	localparam int LEFT_W   = 10;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [WIN_W-1:0] WIN_CAP      = WIN_W'((MAX_WINDOW - 1) | 1);
	localparam logic [WIN_W-1:0] WIN_RESET    = WIN_W'(3);
	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(642);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(482);

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_WINDOW = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} cfg_reg_t;

	// one classified pixel handed from front to back
	typedef struct packed {
		logic [PIX_W-1:0]  pix;
		logic [COL_W-1:0]  col;
		logic [SLOT_W-1:0] slot;
		logic [WIN_W-1:0]  win;
		logic              emit;
		logic              rebuild;
		logic              row_end;
		logic              frame_end;
	} cmd_t;

	// queue status
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_WRITE,
		B_CLEAR,
		B_LS_RD,
		B_HIST_RD,
		B_HIST_WR,
		B_SCAN,
		B_SCAN_LAST,
		B_OUT
	} back_state_t;

endpackage

// File: rtl/core/rwmf_front.sv
// front end: configuration registers, raster position and pixel classification
// depends on rwmf_pkg
module rwmf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rwmf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rwmf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rwmf_pkg::BIN_W-1:0]  blue_in,
	input  logic [rwmf_pkg::BIN_W-1:0]  green_in,
	input  logic [rwmf_pkg::BIN_W-1:0]  red_in,
	input  logic                        q_full,
	output logic                        push,
	output rwmf_pkg::cmd_t              cmd
);
	import rwmf_pkg::*;

	logic [WIN_W-1:0]  win_q;
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;

	logic [WIN_W-1:0]  win_eff;
	logic [CFG_W-1:0]  width_eff;
	logic [CFG_W-1:0]  height_eff;
	logic [CFG_W-1:0]  col_next;
	logic [ROW_W-1:0]  row_next;
	logic [ROW_W-1:0]  win_m1;
	logic              col_wrap;
	logic              row_wrap;

	// effective register values
	always_comb begin
		win_eff = win_q | WIN_W'(1);
		if (win_eff > WIN_CAP) begin
			win_eff = WIN_CAP;
		end
		width_eff = width_q;
		if (width_eff == '0) begin
			width_eff = CFG_W'(1);
		end else if (width_eff > CFG_W'(MAX_WIDTH)) begin
			width_eff = CFG_W'(MAX_WIDTH);
		end
		height_eff = (height_q == '0) ? CFG_W'(1) : height_q;
	end

	// classify the pixel at the current position
	assign col_next = CFG_W'(col_q) + CFG_W'(1);
	assign row_next = row_q + ROW_W'(1);
	assign win_m1   = ROW_W'(win_eff) - ROW_W'(1);
	assign col_wrap = col_next >= width_eff;
	assign row_wrap = row_next >= height_eff;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		cmd.pix       = {red_in, green_in, blue_in};
		cmd.col       = col_q;
		cmd.slot      = slot_q;
		cmd.win       = win_eff;
		cmd.emit      = (row_q >= win_m1) && (CFG_W'(col_q) >= CFG_W'(win_m1));
		cmd.rebuild   = CFG_W'(col_q) == CFG_W'(win_m1);
		cmd.row_end   = col_next == width_eff;
		cmd.frame_end = (col_next == width_eff) && (row_next == height_eff);
	end

	// registers and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= WIN_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW: begin
					win_q  <= cfg_data[WIN_W-1:0];
					col_q  <= '0;
					row_q  <= '0;
					slot_q <= '0;
				end
				REG_WIDTH: begin
					width_q <= cfg_data;
					col_q   <= '0;
					row_q   <= '0;
					slot_q  <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_data;
					col_q    <= '0;
					row_q    <= '0;
					slot_q   <= '0;
				end
				default: begin
				end
			endcase
		end else if (push) begin
			if (col_wrap) begin
				col_q <= '0;
				if (row_wrap) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_next;
					slot_q <= (slot_q == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
				end
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

endmodule

// File: rtl/core/rwmf_queue.sv
// short command queue between front and back
// depends on rwmf_pkg
module rwmf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rwmf_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output rwmf_pkg::cmd_t      head_cmd,
	output rwmf_pkg::q_stat_t   stat
);
	import rwmf_pkg::*;

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_cmd   = entry_q[rd_ptr_q];
	assign stat.full  = count_q == QCNT_W'(QDEPTH);
	assign stat.empty = count_q == '0;
	assign stat.count = count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/rwmf_back.sv
// back end: line store, channel histograms, median scan and output register
// depends on rwmf_pkg
module rwmf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  rwmf_pkg::cmd_t             cmd_in,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rwmf_pkg::BIN_W-1:0] blue_median,
	output logic [rwmf_pkg::BIN_W-1:0] green_median,
	output logic [rwmf_pkg::BIN_W-1:0] red_median,
	output logic                       row_end,
	output logic                       frame_end
);
	import rwmf_pkg::*;

	back_state_t state_q, state_d;

	cmd_t              cmd_q;
	logic [COL_W-1:0]  col_cur_q;
	logic [SLOT_W-1:0] slot_cur_q;
	logic [WIN_W-1:0]  k_q;
	logic              dec_q;
	logic [BIN_W-1:0]  clr_q;
	logic [BIN_W-1:0]  scan_q;
	logic [BIN_W-1:0]  bin_s1;
	logic              scan_vld_s1;
	logic signed [LEFT_W-1:0] left_q [NCH];
	logic              found_q [NCH];
	logic [BIN_W-1:0]  med_q [NCH];
	logic              out_valid_q;
	logic [BIN_W-1:0]  out_med_q [NCH];
	logic              row_end_q;
	logic              frame_end_q;

	logic [PIX_W-1:0]  ls_mem [LS_DEPTH];
	logic [PIX_W-1:0]  ls_rd_q;
	logic              ls_we;
	logic              ls_re;
	logic [LS_AW-1:0]  ls_waddr;
	logic [LS_AW-1:0]  ls_raddr;

	logic [BIN_W-1:0]  hist_mem [NCH][BINS];
	logic [BIN_W-1:0]  hrd_q [NCH];
	logic              hist_we;
	logic              hist_re;
	logic [BIN_W-1:0]  hist_waddr [NCH];
	logic [BIN_W-1:0]  hist_wdata [NCH];
	logic [BIN_W-1:0]  hist_raddr [NCH];

	logic              k_last;
	logic              col_done;
	logic              load_out;
	logic [2*WIN_W-1:0] win_sq;
	logic signed [LEFT_W-1:0] left_nx [NCH];

	assign k_last   = k_q == (cmd_q.win - WIN_W'(1));
	assign col_done = !dec_q && (col_cur_q == cmd_q.col);
	assign win_sq   = (2*WIN_W)'(cmd_q.win) * (2*WIN_W)'(cmd_q.win);
	assign load_out = (state_q == B_OUT) && (!out_valid_q || out_ready);

	// next state and memory controls
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		ls_we    = 1'b0;
		ls_re    = 1'b0;
		hist_we  = 1'b0;
		hist_re  = 1'b0;
		ls_waddr = {cmd_q.slot, cmd_q.col};
		ls_raddr = {slot_cur_q, col_cur_q};
		for (int c = 0; c < NCH; c++) begin
			hist_waddr[c] = ls_rd_q[c*BIN_W +: BIN_W];
			hist_wdata[c] = dec_q ? hrd_q[c] - BIN_W'(1) : hrd_q[c] + BIN_W'(1);
			hist_raddr[c] = ls_rd_q[c*BIN_W +: BIN_W];
		end
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					pop     = 1'b1;
					state_d = B_WRITE;
				end
			end
			B_WRITE: begin
				ls_we = 1'b1;
				if (!cmd_q.emit) begin
					state_d = B_IDLE;
				end else if (cmd_q.rebuild) begin
					state_d = B_CLEAR;
				end else begin
					state_d = B_LS_RD;
				end
			end
			B_CLEAR: begin
				hist_we = 1'b1;
				for (int c = 0; c < NCH; c++) begin
					hist_waddr[c] = clr_q;
					hist_wdata[c] = '0;
				end
				if (clr_q == BIN_W'(BINS - 1)) begin
					state_d = B_LS_RD;
				end
			end
			B_LS_RD: begin
				ls_re   = 1'b1;
				state_d = B_HIST_RD;
			end
			B_HIST_RD: begin
				hist_re = 1'b1;
				state_d = B_HIST_WR;
			end
			B_HIST_WR: begin
				hist_we = 1'b1;
				if (k_last && col_done) begin
					state_d = B_SCAN;
				end else begin
					state_d = B_LS_RD;
				end
			end
			B_SCAN: begin
				hist_re = 1'b1;
				for (int c = 0; c < NCH; c++) begin
					hist_raddr[c] = scan_q;
				end
				if (scan_q == '0) begin
					state_d = B_SCAN_LAST;
				end
			end
			B_SCAN_LAST: begin
				state_d = B_OUT;
			end
			B_OUT: begin
				if (load_out) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// running count from the top bin down
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			left_nx[c] = left_q[c] - LEFT_W'(signed'({2'b00, hrd_q[c]}));
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (ls_we) begin
			ls_mem[ls_waddr] <= cmd_q.pix;
		end
		if (ls_re) begin
			ls_rd_q <= ls_mem[ls_raddr];
		end
	end

	// channel histograms
	for (genvar g = 0; g < NCH; g++) begin : g_hist
		always_ff @(posedge clk) begin
			if (hist_we) begin
				hist_mem[g][hist_waddr[g]] <= hist_wdata[g];
			end
			if (hist_re) begin
				hrd_q[g] <= hist_mem[g][hist_raddr[g]];
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= state_q == B_SCAN;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		bin_s1 <= scan_q;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd_in;
				end
			end
			B_WRITE: begin
				clr_q      <= '0;
				dec_q      <= 1'b1;
				col_cur_q  <= cmd_q.col - COL_W'(cmd_q.win);
				k_q        <= '0;
				slot_cur_q <= cmd_q.slot;
			end
			B_CLEAR: begin
				clr_q      <= clr_q + BIN_W'(1);
				dec_q      <= 1'b0;
				col_cur_q  <= '0;
				k_q        <= '0;
				slot_cur_q <= cmd_q.slot;
			end
			B_HIST_WR: begin
				if (k_last) begin
					k_q        <= '0;
					slot_cur_q <= cmd_q.slot;
					if (dec_q) begin
						dec_q     <= 1'b0;
						col_cur_q <= cmd_q.col;
					end else begin
						col_cur_q <= col_cur_q + COL_W'(1);
					end
				end else begin
					k_q        <= k_q + WIN_W'(1);
					slot_cur_q <= (slot_cur_q == '0) ? SLOT_W'(MAX_WINDOW - 1)
						: slot_cur_q - SLOT_W'(1);
				end
				scan_q <= BIN_W'(BINS - 1);
				for (int c = 0; c < NCH; c++) begin
					left_q[c]  <= LEFT_W'(signed'({1'b0, win_sq[2*WIN_W-1:1]}));
					found_q[c] <= 1'b0;
					med_q[c]   <= '0;
				end
			end
			B_SCAN: begin
				scan_q <= scan_q - BIN_W'(1);
			end
			default: begin
			end
		endcase
		// consume the bin read in the previous cycle
		if (scan_vld_s1) begin
			for (int c = 0; c < NCH; c++) begin
				if (!found_q[c]) begin
					left_q[c] <= left_nx[c];
					if (left_nx[c] < 0) begin
						found_q[c] <= 1'b1;
						med_q[c]   <= bin_s1;
					end
				end
			end
		end
		if (load_out) begin
			for (int c = 0; c < NCH; c++) begin
				out_med_q[c] <= med_q[c];
			end
			row_end_q   <= cmd_q.row_end;
			frame_end_q <= cmd_q.frame_end;
		end
	end

	assign out_valid    = out_valid_q;
	assign blue_median  = out_med_q[0];
	assign green_median = out_med_q[1];
	assign red_median   = out_med_q[2];
	assign row_end      = row_end_q;
	assign frame_end    = frame_end_q;

endmodule

// File: rtl/core/rgb_window_median_filter.sv
// top level of the rgb window median filter
// depends on rwmf_pkg, rwmf_front, rwmf_queue, rwmf_back and the assertion header
//
// channel   | signals                                      | direction
// ----------+----------------------------------------------+----------
// config    | cfg_we, cfg_index, cfg_data                  | in
// pixel in  | in_valid, in_ready, blue_in/green_in/red_in  | in
// median    | out_valid, out_ready, *_median, row_end/frame_end | out
//
// a pixel with no full window only passes B_IDLE and B_WRITE in the back end
// a sliding window drops the old column and adds the new one, the first window
// of a row clears all 256 bins and adds every pixel; both then scan 256 bins
// a two-entry queue lets the front take pixels while the back end works
// a finished median waits in the output register while the back end goes on
// reset clears control state only; the line store needs no clearing
module rgb_window_median_filter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rwmf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [rwmf_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rwmf_pkg::BIN_W-1:0]  blue_in,
	input  logic [rwmf_pkg::BIN_W-1:0]  green_in,
	input  logic [rwmf_pkg::BIN_W-1:0]  red_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rwmf_pkg::BIN_W-1:0]  blue_median,
	output logic [rwmf_pkg::BIN_W-1:0]  green_median,
	output logic [rwmf_pkg::BIN_W-1:0]  red_median,
	output logic                        row_end,
	output logic                        frame_end
);
	import rwmf_pkg::*;

	`include "rgb_window_median_filter_assert.svh"

	cmd_t    push_cmd;
	cmd_t    head_cmd;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	// classify incoming pixels
	rwmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.blue_in   (blue_in),
		.green_in  (green_in),
		.red_in    (red_in),
		.q_full    (q_stat.full),
		.push      (push),
		.cmd       (push_cmd)
	);

	// decoupling queue
	rwmf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	// histogram engine
	rwmf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (!q_stat.empty),
		.cmd_in       (head_cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.blue_median  (blue_median),
		.green_median (green_median),
		.red_median   (red_median),
		.row_end      (row_end),
		.frame_end    (frame_end)
	);

	// checks
	`RWMF_ASSERT_SAME(a_frame_end_row_end, out_valid && frame_end, row_end, "frame end without row end")
	`RWMF_ASSERT_SAME(a_q_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue overfilled")
	`RWMF_ASSERT_NEXT(a_pop_fills, pop && !push, q_stat.count == $past(q_stat.count) - QCNT_W'(1), "pop lost")

endmodule
